[hw/rtl/assert_macros.svh]
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");

// Antecedent in this cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/piq_pkg.sv]
`timescale 1ns / 1ps

package piq_pkg;

   localparam int CAPACITY = 32;
   localparam int OCC_W    = $clog2(CAPACITY + 1);
   localparam int TAG_W    = 16;
   localparam int PRIO_W   = 2;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } piq_status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } piq_slot_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic         enq;
      logic         deq;
      piq_slot_type entry;
   } piq_cmd_type;

   function automatic logic [PRIO_W-1:0] prio_of(input logic [7:0] initial_char);
      logic [PRIO_W-1:0] p;
      p = 2'd3;
      if (initial_char == 8'h50 || initial_char == 8'h70) begin
         p = 2'd1;
      end else if (initial_char == 8'h54 || initial_char == 8'h74) begin
         p = 2'd2;
      end
      return p;
   endfunction

endpackage

[hw/rtl/piq_cell.sv]
`timescale 1ns / 1ps

module piq_cell
   import piq_pkg::*;
(
   input  logic         clock,
   input  piq_cmd_type  cmd,
   input  logic         occupied,
   input  logic         left_keep,
   input  piq_slot_type left_slot,
   input  piq_slot_type right_slot,
   output piq_slot_type slot,
   output logic         keep
);

   piq_slot_type slot_ff;
   piq_slot_type slot_in;

   // entry stays put when it ranks ahead of or level with the new one
   assign keep = occupied && (slot_ff.prio <= cmd.entry.prio);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      priority if (cmd.enq && !keep) begin
         slot_in = left_keep ? cmd.entry : left_slot;
      end else if (cmd.deq) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

[hw/rtl/priority_insertion_queue.sv]
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one request per cycle while results are taken as they appear; the cell row
// shifts all at once for both insert and removal. A waiting result holds off
// requests until the cycle in which it is taken. Reset (synchronous, high) empties the
// queue and clears the result valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_insertion_queue
   import piq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_name_initial,
   input  logic [15:0] req_entry_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_head_tag,
   output logic [1:0]  rsp_head_priority
);

   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff, rsp_valid_in;
   piq_status_type   status_ff, status_in;
   piq_slot_type     head_ff, head_in;

   logic         accept, full, empty;
   piq_cmd_type  cmd;
   piq_slot_type slots [CAPACITY];
   logic         keeps [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == OCC_W'(CAPACITY));
   assign empty     = (occ_ff == '0);

   assign cmd.enq         = accept && (req_operation == OP_ENQUEUE) && !full;
   assign cmd.deq         = accept && (req_operation == OP_DEQUEUE) && !empty;
   assign cmd.entry.prio  = prio_of(req_name_initial);
   assign cmd.entry.tag   = req_entry_tag;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      piq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occ_ff > OCC_W'(i)),
         .left_keep  ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
         .left_slot  ((i == 0) ? cmd.entry : slots[(i == 0) ? 0 : i - 1]),
         .right_slot ((i == CAPACITY - 1) ? slots[i]
                                           : slots[(i == CAPACITY - 1) ? i : i + 1]),
         .slot       (slots[i]),
         .keep       (keeps[i])
      );
   end

   always_comb begin
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      if (cmd.enq) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (cmd.deq) begin
         occ_in = occ_ff - OCC_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         head_in      = '0;
         if (req_operation == OP_ENQUEUE) begin
            status_in = full ? ST_FULL : ST_DONE;
         end else if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_DONE;
            head_in   = slots[0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      head_ff   <= head_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_tag      = head_ff.tag;
   assign rsp_head_priority = head_ff.prio;

   `ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= OCC_W'(CAPACITY))
   `ASSERT_NEXT(a_enq_grows, clock, reset, cmd.enq, occ_ff == $past(occ_ff) + OCC_W'(1))
   `ASSERT_NEXT(a_full_flag, clock, reset,
      accept && (req_operation == OP_ENQUEUE) && full,
      rsp_valid && (rsp_status == ST_FULL) && (occ_ff == $past(occ_ff)))
   `ASSERT_NEXT(a_deq_prio, clock, reset, cmd.deq,
      rsp_valid && (rsp_status == ST_DONE) && (rsp_head_priority != 2'd0))
   `ASSERT_ALWAYS(a_head_sorted, clock, reset,
      (occ_ff < OCC_W'(2)) || (slots[0].prio <= slots[1].prio))

endmodule
